// ===== sv/cjd_pkg.sv =====
// shared widths, constants and tables for the civil date / julian day converter
`timescale 1ns / 1ps

package cjd_pkg;

    // field widths
    localparam int JD_W       = 23;
    localparam int YEAR_W     = 15;
    localparam int MON_W      = 4;
    localparam int DAY_W      = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 23;

    // accept edge to result edge
    localparam int LATENCY = 11;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CAL_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REFORM_DAY = 2'd1;

    // calendar modes
    localparam logic [1:0] MODE_JULIAN    = 2'd0;
    localparam logic [1:0] MODE_GREGORIAN = 2'd1;
    localparam logic [1:0] MODE_REFORM    = 2'd2;

    localparam logic [JD_W-1:0] REFORM_DAY_RST = 23'd2299161;

    // result limits
    localparam logic [JD_W-1:0]          JD_MAX   = 23'd5373484;
    localparam logic signed [YEAR_W-1:0] YEAR_MAX = 15'sd9999;
    localparam logic signed [YEAR_W-1:0] YEAR_MIN = -15'sd4713;

    typedef logic [JD_W-1:0] t_jd;

    // floor(30.6001 * k) for k in 0..16
    function automatic logic [8:0] month_days(input logic [4:0] k);
        logic [8:0] v;
        case (k)
            5'd0:    v = 9'd0;
            5'd1:    v = 9'd30;
            5'd2:    v = 9'd61;
            5'd3:    v = 9'd91;
            5'd4:    v = 9'd122;
            5'd5:    v = 9'd153;
            5'd6:    v = 9'd183;
            5'd7:    v = 9'd214;
            5'd8:    v = 9'd244;
            5'd9:    v = 9'd275;
            5'd10:   v = 9'd306;
            5'd11:   v = 9'd336;
            5'd12:   v = 9'd367;
            5'd13:   v = 9'd397;
            5'd14:   v = 9'd428;
            5'd15:   v = 9'd459;
            5'd16:   v = 9'd489;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== sv/civil_julian_day_converter.sv =====
// civil date <-> julian day number converter, eleven stage pipeline
`timescale 1ns / 1ps
//
//  channel   direction  handshake              payload
//  command   in         start, busy            i_op, i_year, i_month, i_day, i_julian_day
//  result    out        o_valid (one cycle)    o_day_number_out, o_year_out, o_month_out,
//                                              o_day_out
//  config    in         i_cfg_we               i_cfg_idx, i_cfg_data
//
//  one item enters per cycle; the pipeline depth is set by the day-number-to-date path
//  (three reciprocal divisions, each a multiply stage and a correction stage). busy is
//  never raised. reset clears the valid line and loads the calendar registers; payload is
//  not reset. results are strobed for one cycle and the receiver cannot hold them off.

module civil_julian_day_converter
    import cjd_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_op,
    input  logic signed [YEAR_W-1:0]     i_year,
    input  logic [MON_W-1:0]             i_month,
    input  logic [DAY_W-1:0]             i_day,
    input  logic [JD_W-1:0]              i_julian_day,
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data,
    output logic                         o_valid,
    output logic [JD_W-1:0]              o_day_number_out,
    output logic signed [YEAR_W-1:0]     o_year_out,
    output logic [MON_W-1:0]             o_month_out,
    output logic [DAY_W-1:0]             o_day_out
);

    localparam int STG = LATENCY - 1;

    // reciprocal constants: m = floor(2^k / d), quotient then needs at most one +1
    localparam int    X_DIV = 146097;
    localparam int    X_K   = 26;
    localparam longint X_MUL = (longint'(1) << X_K) / X_DIV;
    localparam int    C_DIV = 7305;
    localparam int    C_K   = 28;
    localparam longint C_MUL = (longint'(1) << C_K) / C_DIV;
    localparam int    E_DIV = 306001;
    localparam int    E_K   = 23;
    localparam longint E_MUL = (longint'(1) << E_K) / E_DIV;
    localparam int    H_DIV = 100;
    localparam int    H_K   = 16;
    localparam longint H_MUL = (longint'(1) << H_K) / H_DIV;

    // julian handling test for a day number
    function automatic logic use_julian(input logic [1:0] mode, input t_jd reform,
                                        input logic signed [27:0] jd);
        logic r;
        case (mode)
            MODE_JULIAN: r = 1'b1;
            MODE_REFORM: r = (jd < $signed({5'b00000, reform}));
            default:     r = 1'b0;
        endcase
        return r;
    endfunction

    // configuration registers
    logic [1:0] r_cal_mode;
    t_jd        r_reform_day;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_mode   <= MODE_GREGORIAN;
            r_reform_day <= REFORM_DAY_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_CAL_MODE:   r_cal_mode   <= i_cfg_data[1:0];
                REG_REFORM_DAY: r_reform_day <= i_cfg_data;
                default:        ;
            endcase
        end
    end

    assign busy = 1'b0;

    // valid and op travel alongside the data
    logic             n_accept;
    logic [STG-1:0]   r_vld;
    logic [STG-1:0]   r_op;
    logic             r_valid;

    assign n_accept = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_vld   <= {r_vld[STG-2:0], n_accept};
            r_valid <= r_vld[STG-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_op <= {r_op[STG-2:0], i_op};
    end

    // stage 1: month shift, first gregorian product
    logic signed [15:0] n_yadj1;
    logic [3:0]         n_madj1;
    logic [25:0]        n_xn1;
    logic [34:0]        n_px1;
    logic               n_jul1;

    assign n_yadj1 = (i_month <= 4'd2) ? ($signed({i_year[YEAR_W-1], i_year}) - 16'sd1)
                                       : $signed({i_year[YEAR_W-1], i_year});
    assign n_madj1 = (i_month <= 4'd2) ? (i_month + 4'd12) : i_month;
    assign n_xn1   = {1'b0, i_julian_day, 2'b00} + 26'd128179;
    assign n_px1   = 35'(n_xn1) * 35'(X_MUL);
    assign n_jul1  = use_julian(r_cal_mode, r_reform_day, $signed({5'b00000, i_julian_day}));

    logic signed [15:0] r1_yadj;
    logic [3:0]         r1_madj;
    logic [DAY_W-1:0]   r1_d;
    t_jd                r1_jd;
    logic [34:0]        r1_px;
    logic               r1_jul;

    always_ff @(posedge i_clk) begin
        r1_yadj <= n_yadj1;
        r1_madj <= n_madj1;
        r1_d    <= i_day;
        r1_jd   <= i_julian_day;
        r1_px   <= n_px1;
        r1_jul  <= n_jul1;
    end

    // stage 2: gregorian century term, year products, month table
    logic [25:0]        xn2;
    logic [8:0]         xq0;
    logic [26:0]        x_rem;
    logic [8:0]         xq;
    logic signed [8:0]  n_x2;
    logic signed [15:0] y4716;
    logic signed [26:0] n_t1p2;
    logic [15:0]        n_nh2;
    logic [25:0]        n_ph2;
    logic [8:0]         n_t2_2;

    assign xn2    = {1'b0, r1_jd, 2'b00} + 26'd128179;
    assign xq0    = r1_px[34:26];
    assign x_rem  = 27'(xn2) - 27'(xq0) * 27'(X_DIV);
    assign xq     = xq0 + {8'd0, (x_rem >= 27'(X_DIV))};
    assign n_x2   = $signed(xq - 9'd52);
    assign y4716  = r1_yadj + 16'sd4716;
    assign n_t1p2 = 27'(y4716) * 27'sd1461;
    assign n_nh2  = $unsigned(r1_yadj + 16'sd16500);
    assign n_ph2  = 26'(n_nh2) * 26'(H_MUL);
    assign n_t2_2 = month_days({1'b0, r1_madj} + 5'd1);

    t_jd                r2_jd;
    logic               r2_jul;
    logic signed [8:0]  r2_x;
    logic signed [26:0] r2_t1p;
    logic [15:0]        r2_nh;
    logic [25:0]        r2_ph;
    logic [8:0]         r2_t2;
    logic [DAY_W-1:0]   r2_d;

    always_ff @(posedge i_clk) begin
        r2_jd  <= r1_jd;
        r2_jul <= r1_jul;
        r2_x   <= n_x2;
        r2_t1p <= n_t1p2;
        r2_nh  <= n_nh2;
        r2_ph  <= n_ph2;
        r2_t2  <= n_t2_2;
        r2_d   <= r1_d;
    end

    // stage 3: b for the day path, floored century and partial sum for the date path
    logic signed [24:0] jd25;
    logic signed [24:0] a_greg;
    logic signed [24:0] a_sel;
    logic [23:0]        n_b3;
    logic [9:0]         hq0;
    logic [16:0]        h_rem;
    logic [9:0]         hq;
    logic signed [9:0]  n_a3;
    logic signed [27:0] n_sum3;

    assign jd25   = $signed({2'b00, r2_jd});
    assign a_greg = jd25 + 25'sd1 + 25'(r2_x) - 25'(r2_x >>> 2);
    assign a_sel  = r2_jul ? jd25 : a_greg;
    assign n_b3   = 24'(a_sel + 25'sd1524);
    assign hq0    = r2_ph[25:16];
    assign h_rem  = 17'(r2_nh) - 17'(hq0) * 17'(H_DIV);
    assign hq     = hq0 + {9'd0, (h_rem >= 17'(H_DIV))};
    assign n_a3   = $signed(hq - 10'd165);
    assign n_sum3 = 28'(r2_t1p >>> 2) + $signed({19'd0, r2_t2}) + $signed({23'd0, r2_d})
                    - 28'sd1524;

    logic [23:0]        r3_b;
    logic signed [9:0]  r3_a;
    logic signed [27:0] r3_sum;

    always_ff @(posedge i_clk) begin
        r3_b   <= n_b3;
        r3_a   <= n_a3;
        r3_sum <= n_sum3;
    end

    // stage 4: product for c, gregorian correction b
    logic [27:0]       n_nc4;
    logic [43:0]       n_pc4;
    logic signed [9:0] n_bb4;

    assign n_nc4 = 28'(r3_b) * 28'd20 - 28'd2442;
    assign n_pc4 = 44'(n_nc4) * 44'(C_MUL);
    assign n_bb4 = 10'sd2 - r3_a + (r3_a >>> 2);

    logic [23:0]        r4_b;
    logic [27:0]        r4_nc;
    logic [43:0]        r4_pc;
    logic signed [9:0]  r4_bb;
    logic signed [27:0] r4_sum;

    always_ff @(posedge i_clk) begin
        r4_b   <= r3_b;
        r4_nc  <= n_nc4;
        r4_pc  <= n_pc4;
        r4_bb  <= n_bb4;
        r4_sum <= r3_sum;
    end

    // stage 5: c with correction, reform choice for the date path
    logic [15:0]        cq0;
    logic [28:0]        c_rem;
    logic [14:0]        n_c5;
    logic signed [27:0] jdg;
    logic signed [27:0] n_jd5;

    assign cq0   = r4_pc[43:28];
    assign c_rem = 29'(r4_nc) - 29'(cq0) * 29'(C_DIV);
    assign n_c5  = 15'(cq0 + {15'd0, (c_rem >= 29'(C_DIV))});
    assign jdg   = r4_sum + 28'(r4_bb);
    assign n_jd5 = use_julian(r_cal_mode, r_reform_day, jdg) ? r4_sum : jdg;

    logic [23:0]        r5_b;
    logic [14:0]        r5_c;
    logic signed [27:0] r5_jd;

    always_ff @(posedge i_clk) begin
        r5_b  <= r4_b;
        r5_c  <= n_c5;
        r5_jd <= n_jd5;
    end

    // stage 6: d = floor(1461 c / 4), day number clamp
    logic [25:0] dprod;
    logic [23:0] n_d6;
    t_jd         n_jdo6;

    assign dprod = 26'(r5_c) * 26'd1461;
    assign n_d6  = 24'(dprod >> 2);

    always_comb begin
        if (r5_jd < 28'sd0) begin
            n_jdo6 = '0;
        end else if (r5_jd > $signed({5'b00000, JD_MAX})) begin
            n_jdo6 = JD_MAX;
        end else begin
            n_jdo6 = r5_jd[JD_W-1:0];
        end
    end

    logic [23:0] r6_b;
    logic [23:0] r6_d;
    logic [14:0] r6_c;
    t_jd         r6_jdo;

    always_ff @(posedge i_clk) begin
        r6_b   <= r5_b;
        r6_d   <= n_d6;
        r6_c   <= r5_c;
        r6_jdo <= n_jdo6;
    end

    // stage 7: days into the year count, scaled for the month division
    logic [8:0]  n_bd7;
    logic [22:0] n_ne7;

    assign n_bd7 = 9'(r6_b - r6_d);
    assign n_ne7 = 23'(n_bd7) * 23'd10000;

    logic [8:0]  r7_bd;
    logic [22:0] r7_ne;
    logic [14:0] r7_c;
    t_jd         r7_jdo;

    always_ff @(posedge i_clk) begin
        r7_bd  <= n_bd7;
        r7_ne  <= n_ne7;
        r7_c   <= r6_c;
        r7_jdo <= r6_jdo;
    end

    // stage 8: product for e
    logic [27:0] n_pe8;

    assign n_pe8 = 28'(r7_ne) * 28'(E_MUL);

    logic [8:0]  r8_bd;
    logic [22:0] r8_ne;
    logic [27:0] r8_pe;
    logic [14:0] r8_c;
    t_jd         r8_jdo;

    always_ff @(posedge i_clk) begin
        r8_bd  <= r7_bd;
        r8_ne  <= r7_ne;
        r8_pe  <= n_pe8;
        r8_c   <= r7_c;
        r8_jdo <= r7_jdo;
    end

    // stage 9: e with correction
    logic [4:0]  eq0;
    logic [23:0] e_rem;
    logic [3:0]  n_e9;

    assign eq0   = r8_pe[27:23];
    assign e_rem = 24'(r8_ne) - 24'(eq0) * 24'(E_DIV);
    assign n_e9  = 4'(eq0 + {4'd0, (e_rem >= 24'(E_DIV))});

    logic [8:0]  r9_bd;
    logic [3:0]  r9_e;
    logic [14:0] r9_c;
    t_jd         r9_jdo;

    always_ff @(posedge i_clk) begin
        r9_bd  <= r8_bd;
        r9_e   <= n_e9;
        r9_c   <= r8_c;
        r9_jdo <= r8_jdo;
    end

    // stage 10: day, month and year before the range clamp
    logic [DAY_W-1:0]   n_dd10;
    logic [MON_W-1:0]   n_m10;
    logic signed [15:0] n_y10;

    assign n_dd10 = 5'(r9_bd - month_days({1'b0, r9_e}));
    assign n_m10  = (r9_e <= 4'd13) ? (r9_e - 4'd1) : (r9_e - 4'd13);
    assign n_y10  = $signed({1'b0, r9_c}) - ((r9_e <= 4'd13) ? 16'sd4716 : 16'sd4715);

    logic [DAY_W-1:0]   r10_dd;
    logic [MON_W-1:0]   r10_m;
    logic signed [15:0] r10_y;
    t_jd                r10_jdo;

    always_ff @(posedge i_clk) begin
        r10_dd  <= n_dd10;
        r10_m   <= n_m10;
        r10_y   <= n_y10;
        r10_jdo <= r9_jdo;
    end

    // output stage: date clamp and op select
    t_jd                      n_day_number_out;
    logic signed [YEAR_W-1:0] n_year_out;
    logic [MON_W-1:0]         n_month_out;
    logic [DAY_W-1:0]         n_day_out;

    always_comb begin
        n_day_number_out = '0;
        n_year_out       = '0;
        n_month_out      = '0;
        n_day_out        = '0;
        if (!r_op[STG-1]) begin
            n_day_number_out = r10_jdo;
        end else if (r10_y > 16'(YEAR_MAX)) begin
            n_year_out  = YEAR_MAX;
            n_month_out = 4'd12;
            n_day_out   = 5'd31;
        end else if (r10_y < 16'(YEAR_MIN)) begin
            n_year_out  = YEAR_MIN;
            n_month_out = 4'd1;
            n_day_out   = 5'd1;
        end else begin
            n_year_out  = r10_y[YEAR_W-1:0];
            n_month_out = r10_m;
            n_day_out   = r10_dd;
        end
    end

    t_jd                      r_day_number_out;
    logic signed [YEAR_W-1:0] r_year_out;
    logic [MON_W-1:0]         r_month_out;
    logic [DAY_W-1:0]         r_day_out;

    always_ff @(posedge i_clk) begin
        r_day_number_out <= n_day_number_out;
        r_year_out       <= n_year_out;
        r_month_out      <= n_month_out;
        r_day_out        <= n_day_out;
    end

    assign o_valid          = r_valid;
    assign o_day_number_out = r_day_number_out;
    assign o_year_out       = r_year_out;
    assign o_month_out      = r_month_out;
    assign o_day_out        = r_day_out;

endmodule

// ===== sv/cjd_checker.sv =====
// port level checks for the converter, bound to the top level
`timescale 1ns / 1ps

module cjd_checker
    import cjd_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     start,
    input logic                     busy,
    input logic                     o_valid,
    input logic [JD_W-1:0]          o_day_number_out,
    input logic signed [YEAR_W-1:0] o_year_out,
    input logic [MON_W-1:0]         o_month_out,
    input logic [DAY_W-1:0]         o_day_out
);

    // every result comes from an item accepted a fixed latency earlier
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LATENCY))
        else $error("result without an item accepted at the pipeline latency");

    // day number results stay inside the clamp
    a_jd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_day_number_out <= JD_MAX))
        else $error("day number above the clamp");

    // a zero month means a day number result, so the date fields are clear
    a_date_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_month_out == '0)) |-> ((o_year_out == '0) && (o_day_out == '0)))
        else $error("date fields set on a day number result");

    // a date result has a clear day number and a year inside the clamp
    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_month_out != '0)) |->
            ((o_day_number_out == '0) && (o_month_out <= 4'd12)
             && (o_year_out <= YEAR_MAX) && (o_year_out >= YEAR_MIN)))
        else $error("date result out of range");

endmodule

bind civil_julian_day_converter cjd_checker u_cjd_checker (.*);

// ===== tb/civil_julian_day_checker.sv =====
// result checker for the civil date / julian day converter: predicts each item and compares
`timescale 1ns / 1ps

module civil_julian_day_checker
    import cjd_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic                     i_busy,
    input  logic                     i_op,
    input  logic signed [YEAR_W-1:0] i_year,
    input  logic [MON_W-1:0]         i_month,
    input  logic [DAY_W-1:0]         i_day,
    input  logic [JD_W-1:0]          i_julian_day,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                     i_valid,
    input  logic [JD_W-1:0]          i_day_number_out,
    input  logic signed [YEAR_W-1:0] i_year_out,
    input  logic [MON_W-1:0]         i_month_out,
    input  logic [DAY_W-1:0]         i_day_out,
    output int                       o_fail_count,
    output int                       o_pending,
    output int                       o_checked
);

    typedef struct packed {
        t_jd                     day_number;
        logic signed [YEAR_W-1:0] year;
        logic [MON_W-1:0]        month;
        logic [DAY_W-1:0]        day;
    } t_conv_result;

    // results still owed by the pipeline, oldest first
    t_conv_result expected_q[$];

    // shadow copies of the calendar registers
    logic [1:0] cal_mode;
    t_jd        reform_day;

    int fails   = 0;
    int checked = 0;

    // division rounding toward minus infinity, divisor always positive here
    function automatic longint floor_div(input longint n, input longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0)
            q -= 1;
        return q;
    endfunction

    // whether a day number is reckoned in the julian calendar
    function automatic bit julian_reckoned(input longint jd, input logic [1:0] mode,
                                           input t_jd reform);
        longint r;
        r = reform;
        case (mode)
            MODE_JULIAN: return 1'b1;
            MODE_REFORM: return jd < r;
            default:     return 1'b0;
        endcase
    endfunction

    // civil date to julian day number, saturated to the legal day range
    function automatic t_jd day_from_date(input logic signed [YEAR_W-1:0] yr,
                                          input logic [MON_W-1:0] mon,
                                          input logic [DAY_W-1:0] dom,
                                          input logic [1:0] mode, input t_jd reform);
        longint y, m, dd, a, b, jd, lim;
        y   = yr;
        m   = mon;
        dd  = dom;
        lim = JD_MAX;
        if (m <= 2) begin
            y -= 1;
            m += 12;
        end
        a  = floor_div(y, 100);
        b  = 2 - a + floor_div(a, 4);
        jd = floor_div(1461 * (y + 4716), 4) + floor_div(306001 * (m + 1), 10000)
             + dd + b - 1524;
        // the reform test looks at the gregorian count before the correction comes out
        if (julian_reckoned(jd, mode, reform))
            jd -= b;
        if (jd < 0)
            jd = 0;
        if (jd > lim)
            jd = lim;
        return jd[JD_W-1:0];
    endfunction

    // julian day number to civil date, saturated to the year limits
    function automatic t_conv_result date_from_day(input t_jd jd_in, input logic [1:0] mode,
                                                   input t_jd reform);
        longint jd, x, a, b, c, d, e, y, m, dd;
        t_conv_result r;
        jd = jd_in;
        if (julian_reckoned(jd, mode, reform)) begin
            a = jd;
        end else begin
            x = floor_div(4 * jd - 7468865, 146097);
            a = jd + 1 + x - floor_div(x, 4);
        end
        b  = a + 1524;
        c  = floor_div(20 * b - 2442, 7305);
        d  = floor_div(1461 * c, 4);
        e  = floor_div(10000 * (b - d), 306001);
        dd = b - d - floor_div(306001 * e, 10000);
        if (e <= 13) begin
            m = e - 1;
            y = c - 4716;
        end else begin
            m = e - 13;
            y = c - 4715;
        end
        if (y > 9999) begin
            y  = 9999;
            m  = 12;
            dd = 31;
        end else if (y < -4713) begin
            y  = -4713;
            m  = 1;
            dd = 1;
        end
        r       = '0;
        r.year  = y[YEAR_W-1:0];
        r.month = m[MON_W-1:0];
        r.day   = dd[DAY_W-1:0];
        return r;
    endfunction

    // compare results, queue predictions, follow register writes
    always @(posedge i_clk) begin
        t_conv_result got;
        t_conv_result want;
        if (!i_rst_n) begin
            cal_mode   <= MODE_GREGORIAN;
            reform_day <= REFORM_DAY_RST;
        end else begin
            if (i_valid !== 1'b0) begin
                got.day_number = i_day_number_out;
                got.year       = i_year_out;
                got.month      = i_month_out;
                got.day        = i_day_out;
                if (expected_q.size() == 0) begin
                    $error("result with no item outstanding");
                    fails++;
                end else begin
                    want = expected_q.pop_front();
                    checked++;
                    if (got.day_number !== want.day_number) begin
                        $error("day_number_out: expected %0d, actual %0d",
                               want.day_number, got.day_number);
                        fails++;
                    end
                    if (got.year !== want.year) begin
                        $error("year_out: expected %0d, actual %0d", want.year, got.year);
                        fails++;
                    end
                    if (got.month !== want.month) begin
                        $error("month_out: expected %0d, actual %0d", want.month, got.month);
                        fails++;
                    end
                    if (got.day !== want.day) begin
                        $error("day_out: expected %0d, actual %0d", want.day, got.day);
                        fails++;
                    end
                end
            end
            if (i_start && i_busy === 1'b0) begin
                if (i_op == 1'b0) begin
                    want            = '0;
                    want.day_number = day_from_date(i_year, i_month, i_day,
                                                    cal_mode, reform_day);
                end else begin
                    want = date_from_day(i_julian_day, cal_mode, reform_day);
                end
                expected_q.push_back(want);
            end
            // indexes beyond the two registers are dropped
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_CAL_MODE:   cal_mode   <= i_cfg_data[1:0];
                    REG_REFORM_DAY: reform_day <= i_cfg_data[JD_W-1:0];
                    default: ;
                endcase
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_q.size();
        o_checked    <= checked;
    end

endmodule

// ===== tb/civil_julian_day_converter_test.sv =====
// top of the converter testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module civil_julian_day_converter_test;
    import cjd_pkg::*;

    // indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;
    // the unused mode code, treated as gregorian
    localparam logic [1:0] MODE_ALIAS = 2'd3;

    localparam int REFORM_TOP   = 8388607;
    localparam int PHASE_ITEMS  = 175;
    localparam int DRAIN_LIMIT  = 40 * LATENCY;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     start;
    logic                     busy;
    logic                     i_op;
    logic signed [YEAR_W-1:0] i_year;
    logic [MON_W-1:0]         i_month;
    logic [DAY_W-1:0]         i_day;
    logic [JD_W-1:0]          i_julian_day;
    logic                     i_cfg_we;
    logic [CFG_IDX_W-1:0]     i_cfg_idx;
    logic [CFG_DATA_W-1:0]    i_cfg_data;
    logic                     o_valid;
    logic [JD_W-1:0]          o_day_number_out;
    logic signed [YEAR_W-1:0] o_year_out;
    logic [MON_W-1:0]         o_month_out;
    logic [DAY_W-1:0]         o_day_out;

    int fail_count;
    int pending;
    int checked;

    int idle_rate    = 0;
    int date_items   = 0;
    int day_items    = 0;
    int reg_writes   = 0;
    int settings_run = 1;
    int cur_reform   = REFORM_DAY_RST;

    always #5 i_clk = ~i_clk;

    civil_julian_day_converter dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_op             (i_op),
        .i_year           (i_year),
        .i_month          (i_month),
        .i_day            (i_day),
        .i_julian_day     (i_julian_day),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .o_valid          (o_valid),
        .o_day_number_out (o_day_number_out),
        .o_year_out       (o_year_out),
        .o_month_out      (o_month_out),
        .o_day_out        (o_day_out)
    );

    civil_julian_day_checker conv_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .i_busy           (busy),
        .i_op             (i_op),
        .i_year           (i_year),
        .i_month          (i_month),
        .i_day            (i_day),
        .i_julian_day     (i_julian_day),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (o_valid),
        .i_day_number_out (o_day_number_out),
        .i_year_out       (o_year_out),
        .i_month_out      (o_month_out),
        .i_day_out        (o_day_out),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_checked        (checked)
    );

    // watchdog
    initial begin
        #5_000_000;
        $display("civil_julian_day_converter verification failed");
        $finish;
    end

    // present one item and hold it until accepted, then maybe idle for a burst
    task automatic issue(input logic op, input logic signed [YEAR_W-1:0] y,
                         input logic [MON_W-1:0] m, input logic [DAY_W-1:0] d,
                         input t_jd jd);
        i_op         <= op;
        i_year       <= y;
        i_month      <= m;
        i_day        <= d;
        i_julian_day <= jd;
        start        <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        if (op == 1'b0)
            date_items++;
        else
            day_items++;
        if (idle_rate != 0 && $urandom_range(1, idle_rate) == 1) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
    endtask

    // wait until every predicted result has come back, with a bound
    task automatic wait_drained();
        int n;
        n = 0;
        do begin
            @(posedge i_clk);
            n++;
        end while (pending != 0 && n < DRAIN_LIMIT);
    endtask

    // write both calendar registers, the mode with junk in its upper bits, after an optional spare write
    task automatic set_calendar(input logic [1:0] mode, input int reform, input bit spare);
        logic [CFG_DATA_W-1:0] v;
        wait_drained();
        i_cfg_we <= 1'b1;
        if (spare) begin
            i_cfg_idx  <= ($urandom_range(0, 1) == 0) ? REG_SPARE_LO : REG_SPARE_HI;
            i_cfg_data <= CFG_DATA_W'($urandom);
            @(posedge i_clk);
            reg_writes++;
        end
        v          = CFG_DATA_W'($urandom);
        v[1:0]     = mode;
        i_cfg_idx  <= REG_CAL_MODE;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_idx  <= REG_REFORM_DAY;
        i_cfg_data <= CFG_DATA_W'(reform);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        reg_writes += 2;
        cur_reform = reform & REFORM_TOP;
        settings_run++;
    endtask

    // one random item, mostly legal dates and day numbers, some near edges
    task automatic rand_item();
        int                   sel;
        int                   y;
        int                   jd;
        logic                 op;
        logic [MON_W-1:0]     m;
        logic [DAY_W-1:0]     d;
        sel = $urandom_range(0, 9);
        op  = 1'($urandom_range(0, 1));
        y   = int'($urandom_range(0, 14711)) - 4712;
        m   = MON_W'($urandom_range(1, 12));
        d   = DAY_W'($urandom_range(1, 31));
        jd  = $urandom_range(0, JD_MAX);
        case (sel)
            0: y = int'($urandom_range(0, 32767)) - 16384;
            1: begin
                // close to the reform day, from either side
                y = (cur_reform * 4 - 6884232) / 1461 + int'($urandom_range(0, 2)) - 1;
                if (y > 16383)
                    y = 16383;
                jd = cur_reform + int'($urandom_range(0, 6)) - 3;
                if (jd < 0)
                    jd = 0;
                if (jd > REFORM_TOP)
                    jd = REFORM_TOP;
            end
            2: m = MON_W'($urandom_range(0, 15));
            3: d = DAY_W'($urandom_range(0, 31));
            4: jd = $urandom_range(0, REFORM_TOP);
            5: jd = ($urandom_range(0, 1) == 0) ? int'($urandom_range(0, 3))
                                                : int'(JD_MAX) + int'($urandom_range(0, 6)) - 3;
            default: ;
        endcase
        issue(op, YEAR_W'(y), m, d, JD_W'(jd));
    endtask

    // random items with the idle pattern changing every few dozen
    task automatic run_random(input int count, input bit quiet);
        for (int i = 0; i < count; i++) begin
            if (quiet)
                idle_rate = 0;
            else if (i % 48 == 0)
                case ($urandom_range(0, 2))
                    0:       idle_rate = 0;
                    1:       idle_rate = 3;
                    default: idle_rate = 12;
                endcase
            rand_item();
        end
        start <= 1'b0;
    endtask

    // a calendar setting: reform boundary items first, then random ones
    task automatic run_phase(input logic [1:0] mode, input int reform, input bit spare,
                             input bit quiet);
        int lo;
        int hi;
        set_calendar(mode, reform, spare);
        lo = (cur_reform > 0) ? cur_reform - 1 : 0;
        hi = (cur_reform < REFORM_TOP) ? cur_reform + 1 : REFORM_TOP;
        issue(1'b1, 0, 0, 0, JD_W'(lo));
        issue(1'b1, 0, 0, 0, JD_W'(cur_reform));
        issue(1'b1, 0, 0, 0, JD_W'(hi));
        issue(1'b0, 1582, 10, 4, 0);
        issue(1'b0, 1582, 10, 15, 0);
        run_random(PHASE_ITEMS, quiet);
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        start        <= 1'b0;
        i_op         <= 1'b0;
        i_year       <= '0;
        i_month      <= '0;
        i_day        <= '0;
        i_julian_day <= '0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= REG_CAL_MODE;
        i_cfg_data   <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed items under the reset calendar
        idle_rate = 3;
        issue(1'b0, -4712, 1, 1, 0);
        issue(1'b0, 9999, 12, 31, 0);
        issue(1'b0, -16384, 0, 0, 0);
        issue(1'b0, 16383, 15, 31, JD_W'(REFORM_TOP));
        issue(1'b0, 2000, 1, 1, 0);
        issue(1'b0, 1582, 10, 15, 0);
        issue(1'b0, 1582, 10, 4, 0);
        issue(1'b0, 0, 2, 29, 0);
        issue(1'b0, -1, 3, 1, 0);
        issue(1'b0, -101, 1, 1, 0);
        issue(1'b0, 1900, 2, 28, 0);
        issue(1'b0, 2024, 0, 15, 0);
        issue(1'b0, 2024, 13, 1, 0);
        issue(1'b0, 2024, 3, 0, 0);
        issue(1'b1, 0, 0, 0, 0);
        issue(1'b1, 0, 0, 0, 1);
        issue(1'b1, 0, 0, 0, JD_MAX);
        issue(1'b1, 0, 0, 0, JD_MAX + 1);
        issue(1'b1, 0, 0, 0, JD_W'(REFORM_TOP));
        issue(1'b1, 0, 0, 0, 2299160);
        issue(1'b1, 0, 0, 0, 2299161);
        issue(1'b1, 0, 0, 0, 2451545);
        issue(1'b1, 0, 0, 0, 1721424);
        issue(1'b1, 16383, 15, 31, 2460000);
        run_random(PHASE_ITEMS, 1'b0);

        // sweep of calendar settings, extremes of the reform day included
        run_phase(MODE_JULIAN,    REFORM_DAY_RST, 1'b1, 1'b0);
        run_phase(MODE_REFORM,    REFORM_DAY_RST, 1'b0, 1'b0);
        run_phase(MODE_REFORM,    0,              1'b1, 1'b0);
        run_phase(MODE_REFORM,    JD_MAX,         1'b0, 1'b0);
        run_phase(MODE_ALIAS,     2299160,        1'b1, 1'b0);
        run_phase(MODE_REFORM,    REFORM_TOP,     1'b0, 1'b0);
        run_phase(MODE_REFORM,    $urandom_range(0, JD_MAX), 1'b1, 1'b0);
        // last stretch runs back to back
        run_phase(MODE_GREGORIAN, REFORM_DAY_RST, 1'b0, 1'b1);

        wait_drained();
        repeat (LATENCY + 5) @(posedge i_clk);
        $display("covered %0d date-to-day and %0d day-to-date items, %0d results compared",
                 date_items, day_items, checked);
        $display("over %0d calendar settings with %0d register writes", settings_run,
                 reg_writes);
        if (pending != 0)
            $error("%0d results never arrived", pending);
        if (fail_count == 0 && pending == 0) begin
            $display("civil_julian_day_converter verification clean");
        end else begin
            $display("civil_julian_day_converter verification failed");
        end
        $finish;
    end

endmodule
